@@ rtl/polar_seam_split_line_mapper_unit_macros.svh @@
// Assertion helpers used by the mapper back end.
`ifndef POLAR_SEAM_SPLIT_LINE_MAPPER_UNIT_MACROS_SVH
`define POLAR_SEAM_SPLIT_LINE_MAPPER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define PSSLM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PSSLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSSLM_ASSERT(lbl, clk, rstn, prop, msg)
`define PSSLM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/psslm_pkg.sv @@
package psslm_pkg;
	localparam int CW = 16;          // coordinate width
	localparam int AB = 16;          // angle bits per full circle
	localparam int AZW = 18;
	localparam int RW = 17;
	localparam int NW = 21;          // normalization arithmetic width
	localparam int XW = 40;          // CORDIC x/y width
	localparam int ZW = 34;          // CORDIC angle accumulator width
	localparam int STEPS = 24;
	localparam int SQW = 32;
	localparam int PW = 38;          // seam numerator width
	localparam int DW = 20;          // seam divisor width
	localparam int CFG_LOW = 0;
	localparam int CFG_HIGH = 1;
	localparam logic [2:0] LAST_IDX = 3'd4;

	typedef struct packed {
		logic start;
		logic signed [CW-1:0] north;
		logic signed [CW-1:0] east;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SUM, ST_ITER, ST_FIN, ST_NORM1, ST_NORM2, ST_SEAM,
		ST_MUL1, ST_MUL2, ST_DINIT, ST_DIV, ST_CLAMP, ST_EMIT
	} state_t;

	function automatic logic [ZW-1:0] atan_turn(input logic [4:0] i);
		logic [ZW-1:0] v;
		case (i)
			5'd0: v = ZW'(32'h20000000);
			5'd1: v = ZW'(32'h12E4051E);
			5'd2: v = ZW'(32'h09FB385B);
			5'd3: v = ZW'(32'h051111D4);
			5'd4: v = ZW'(32'h028B0D43);
			5'd5: v = ZW'(32'h0145D7E1);
			5'd6: v = ZW'(32'h00A2F61E);
			5'd7: v = ZW'(32'h00517C55);
			5'd8: v = ZW'(32'h0028BE53);
			5'd9: v = ZW'(32'h00145F2F);
			5'd10: v = ZW'(32'h000A2F98);
			5'd11: v = ZW'(32'h000517CC);
			5'd12: v = ZW'(32'h00028BE6);
			5'd13: v = ZW'(32'h000145F3);
			5'd14: v = ZW'(32'h0000A2FA);
			5'd15: v = ZW'(32'h0000517D);
			5'd16: v = ZW'(32'h000028BE);
			5'd17: v = ZW'(32'h0000145F);
			5'd18: v = ZW'(32'h00000A30);
			5'd19: v = ZW'(32'h00000518);
			5'd20: v = ZW'(32'h0000028C);
			5'd21: v = ZW'(32'h00000146);
			5'd22: v = ZW'(32'h000000A3);
			5'd23: v = ZW'(32'h00000051);
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

@@ rtl/polar_seam_split_line_mapper_unit.sv @@
// Maps polyline vertices (east, north) to (azimuth, range). Azimuth comes from a 24-step
// iterative CORDIC, range from a bit-serial square root run alongside it; the back end
// takes a vertex only when idle, once the last result item of the one before is loaded.
// A vertex that crosses the display seam adds a serial divider for the seam range, with
// its multiply and setup states, plus four extra result items; a seam with a zero azimuth
// step skips the divider. A stalled output holds the back end. A two-item input queue lets
// vertices arrive while one is still being worked on.
module polar_seam_split_line_mapper_unit import psslm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,  // east_coord[15:0], north_coord[31:16]
	input  logic                  s_axis_tuser,  // start_line
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [39:0]           m_axis_tdata,  // azimuth[17:0], range[34:18], zero fill
	output logic                  m_axis_tlast,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [AZW-1:0]        cfg_wdata
);
	logic signed [AZW-1:0] low_q, high_q;
	item_t in_item, q_item;
	logic q_valid, q_take;
	logic [AZW-1:0] azimuth;
	logic [RW-1:0] range_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= -AZW'(32768);
			high_q <= AZW'(32768);
		end else if (cfg_we) begin
			if (cfg_index == 1'(CFG_LOW)) low_q <= cfg_wdata;
			else high_q <= cfg_wdata;
		end
	end

	assign in_item.start = s_axis_tuser;
	assign in_item.north = s_axis_tdata[31:16];
	assign in_item.east = s_axis_tdata[15:0];

	psslm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	psslm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.low_edge(low_q), .high_edge(high_q),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_azimuth(azimuth), .out_range(range_w), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'b0, range_w, azimuth};
endmodule

@@ rtl/psslm_front.sv @@
module psslm_front import psslm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  q_valid,
	input  logic  q_take,
	output item_t q_item
);
	item_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_take);
		end
	end
endmodule

@@ rtl/psslm_back.sv @@
`include "polar_seam_split_line_mapper_unit_macros.svh"
module psslm_back import psslm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic signed [AZW-1:0] low_edge,
	input  logic signed [AZW-1:0] high_edge,
	input  logic                  q_valid,
	output logic                  q_take,
	input  item_t                 q_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [AZW-1:0]        out_azimuth,
	output logic [RW-1:0]         out_range,
	output logic                  out_last
);
	localparam logic signed [NW-1:0] FULL = NW'(1) <<< AB;
	localparam logic signed [NW-1:0] HALF = NW'(1) <<< (AB - 1);
	localparam logic [NW-1:0] LOMASK = (NW'(1) << AB) - NW'(1);

	state_t state_q, state_d;
	logic signed [CW-1:0] e_q, n_q;
	logic start_q, zero_q;
	logic signed [XW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q;
	logic [4:0] iter_q;
	logic [SQW-1:0] sqe_q, sqn_q, s_q;
	logic [SQW+1:0] rem_q, rem2, trial;
	logic [RW-1:0] root_q;
	logic signed [NW-1:0] az_q, low_w, high_w, t1, d2;
	logic [RW-1:0] rng_q, prev_rng_q, ty_q;
	logic signed [AZW-1:0] prev_az_q, first_q, second_q;
	logic has_prev_q, seam_q;
	logic signed [AZW:0] dlt;
	logic signed [DW-1:0] step_q, step_c;
	logic signed [AZW-1:0] dy_q;
	logic signed [AZW:0] ep_q;
	logic signed [PW-1:0] p1_q, p2_q, num;
	logic [PW-1:0] nmag_q, quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0] drem_q, drem2;
	logic neg_q;
	logic [5:0] cnt_q;
	logic [2:0] idx_q;
	logic out_valid_q, out_last_q, out_load;
	logic [AZW-1:0] out_az_q;
	logic [RW-1:0] out_rng_q;
	logic [CW-1:0] ae, an;
	logic seam_now;

	assign low_w = NW'(low_edge);
	assign high_w = NW'(high_edge);
	assign q_take = (state_q == ST_IDLE) && q_valid;
	assign out_load = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_azimuth = out_az_q;
	assign out_range = out_rng_q;
	assign out_last = out_last_q;

	assign ae = e_q[CW-1] ? CW'(-e_q) : e_q;
	assign an = n_q[CW-1] ? CW'(-n_q) : n_q;
	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign rem2 = {rem_q[SQW-1:0], s_q[SQW-1:SQW-2]};
	assign trial = {{(SQW+2-RW-2){1'b0}}, root_q, 2'b01};
	assign t1 = low_w - az_q + FULL - NW'(1);
	assign d2 = az_q - high_w;
	assign dlt = AZW'(az_q) - prev_az_q;
	assign seam_now = has_prev_q && !start_q && ((dlt > (AZW+1)'(HALF)) || (dlt < -(AZW+1)'(HALF)));
	assign step_c = (dlt > 0) ? DW'(dlt) - DW'(FULL) : DW'(dlt) + DW'(FULL);
	assign num = p1_q + p2_q;
	assign drem2 = {drem_q[DW-1:0], nmag_q[PW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_SQ;
			ST_SQ: state_d = ST_SUM;
			ST_SUM: state_d = ST_ITER;
			ST_ITER: if (iter_q == 5'(STEPS - 1)) state_d = ST_FIN;
			ST_FIN: state_d = ST_NORM1;
			ST_NORM1: state_d = ST_NORM2;
			ST_NORM2: state_d = ST_SEAM;
			ST_SEAM: begin
				if (seam_now && step_c != '0) state_d = ST_MUL1;
				else state_d = ST_EMIT;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DINIT;
			ST_DINIT: state_d = ST_DIV;
			ST_DIV: if (cnt_q == 6'(PW - 1)) state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_EMIT;
			ST_EMIT: if (out_load && idx_q == LAST_IDX) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				e_q <= q_item.east;
				n_q <= q_item.north;
				start_q <= q_item.start;
			end
			ST_SQ: begin
				sqe_q <= SQW'(ae) * SQW'(ae);
				sqn_q <= SQW'(an) * SQW'(an);
				zero_q <= (e_q == '0) && (n_q == '0);
				iter_q <= '0;
				// prerotate by a quarter turn when north is negative
				if (n_q[CW-1]) begin
					if (!e_q[CW-1]) begin
						x_q <= XW'(e_q) <<< 20;
						y_q <= -(XW'(n_q) <<< 20);
						z_q <= ZW'(1) <<< 30;
					end else begin
						x_q <= -(XW'(e_q) <<< 20);
						y_q <= XW'(n_q) <<< 20;
						z_q <= -(ZW'(1) <<< 30);
					end
				end else begin
					x_q <= XW'(n_q) <<< 20;
					y_q <= XW'(e_q) <<< 20;
					z_q <= '0;
				end
			end
			ST_SUM: begin
				s_q <= sqe_q + sqn_q;
				rem_q <= '0;
				root_q <= '0;
			end
			ST_ITER: begin
				if (!y_q[XW-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_turn(iter_q);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_turn(iter_q);
				end
				iter_q <= iter_q + 5'd1;
				if (iter_q < 5'(SQW / 2)) begin
					s_q <= s_q << 2;
					if (rem2 >= trial) begin
						rem_q <= rem2 - trial;
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q <= rem2;
						root_q <= {root_q[RW-2:0], 1'b0};
					end
				end
			end
			ST_FIN: begin
				az_q <= zero_q ? '0 : NW'((z_q + (ZW'(1) <<< (AB - 1))) >>> (32 - AB));
				rng_q <= (rem_q > (SQW+2)'(root_q)) ? root_q + RW'(1) : root_q;
			end
			ST_NORM1: begin
				if (az_q < low_w) az_q <= az_q + (t1 & ~LOMASK);
			end
			ST_NORM2: begin
				if (az_q >= high_w) begin
					az_q <= NW'(signed'(AZW'(az_q - ((d2 & ~LOMASK) + FULL))));
				end else begin
					az_q <= NW'(signed'(AZW'(az_q)));
				end
			end
			ST_SEAM: begin
				seam_q <= seam_now;
				idx_q <= seam_now ? 3'd0 : LAST_IDX;
				step_q <= step_c;
				ty_q <= prev_rng_q;
				if (dlt > 0) begin
					first_q <= low_edge;
					second_q <= high_edge;
					ep_q <= low_edge - prev_az_q;
				end else begin
					first_q <= high_edge;
					second_q <= low_edge;
					ep_q <= high_edge - prev_az_q;
				end
				dy_q <= AZW'(rng_q) - AZW'(prev_rng_q);
			end
			ST_MUL1: p1_q <= PW'(dy_q) * PW'(ep_q);
			ST_MUL2: p2_q <= PW'(signed'({1'b0, prev_rng_q})) * PW'(step_q);
			ST_DINIT: begin
				nmag_q <= num[PW-1] ? PW'(-num) : num;
				dvs_q <= step_q[DW-1] ? DW'(-step_q) : step_q;
				neg_q <= num[PW-1] ^ step_q[DW-1];
				drem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				nmag_q <= nmag_q << 1;
				cnt_q <= cnt_q + 6'd1;
				if (drem2 >= {1'b0, dvs_q}) begin
					drem_q <= drem2 - {1'b0, dvs_q};
					quo_q <= {quo_q[PW-2:0], 1'b1};
				end else begin
					drem_q <= drem2;
					quo_q <= {quo_q[PW-2:0], 1'b0};
				end
			end
			ST_CLAMP: begin
				if (neg_q) ty_q <= (quo_q > PW'(65536)) ? RW'(-65536) : RW'(-quo_q);
				else ty_q <= (quo_q > PW'(65535)) ? RW'(65535) : RW'(quo_q);
			end
			ST_EMIT: if (out_load) idx_q <= idx_q + 3'd1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_az_q <= '0;
			prev_rng_q <= '0;
			has_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_EMIT && out_load) begin
				out_valid_q <= 1'b1;
				if (idx_q == LAST_IDX) begin
					prev_az_q <= AZW'(az_q);
					prev_rng_q <= rng_q;
					has_prev_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_load) begin
			out_last_q <= (idx_q == LAST_IDX);
			case (idx_q)
				3'd0: begin out_az_q <= first_q; out_rng_q <= ty_q; end
				3'd1: begin out_az_q <= first_q; out_rng_q <= '1; end
				3'd2: begin out_az_q <= second_q; out_rng_q <= '1; end
				3'd3: begin out_az_q <= second_q; out_rng_q <= ty_q; end
				default: begin out_az_q <= AZW'(az_q); out_rng_q <= rng_q; end
			endcase
		end
	end

	`PSSLM_ASSERT(a_take_idle, clk, arst_n, q_take |-> state_q == ST_IDLE, "take outside idle")
	`PSSLM_ASSERT(a_marker_not_last, clk, arst_n, (out_valid_q && out_rng_q == '1) |-> !out_last_q, "marker flagged last")
	`PSSLM_ASSERT(a_last_keeps, clk, arst_n, (state_q == ST_EMIT && out_load && idx_q == LAST_IDX) |=> has_prev_q, "vertex not kept")
	`PSSLM_ASSERT(a_seam_only_prev, clk, arst_n, (state_q == ST_EMIT && idx_q == 3'd0) |-> seam_q, "seam without previous vertex")
	`PSSLM_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid_q, "output valid in reset")
endmodule

@@ dv/tb.sv @@
module tb;
	import psslm_pkg::*;

	typedef struct {
		logic signed [AZW-1:0] az;
		logic signed [RW-1:0]  rng;
		logic                  last;
	} point_t;

	localparam longint FULL_CIRCLE = 64'sd65536;
	localparam longint HALF_CIRCLE = 64'sd32768;
	localparam int     STALL_LIMIT = 4000;
	localparam int     SETTLE_CYCLES = 150;

	localparam longint ATAN_TURNS [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata = '0;   // east_coord[15:0], north_coord[31:16]
	logic                 s_axis_tuser = 1'b0; // start_line
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [39:0]          m_axis_tdata;        // azimuth[17:0], range[34:18], zero fill
	logic                 m_axis_tlast;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = 1'b0;
	logic [AZW-1:0]       cfg_wdata = '0;

	item_t  vertex_q[$];
	point_t point_q[$];
	item_t  drv_item;
	int     send_idle_pct = 38;
	int     recv_idle_pct = 74;
	int     errors = 0;
	int     points_seen = 0;
	int     hold_left = 0;
	bit     hold_done = 1'b0;
	int     quiet_cycles = 0;

	// mirror of the block's window and line state
	longint win_low = -32768;
	longint win_high = 32768;
	longint prev_az = 0;
	longint prev_rng = 0;
	bit     has_prev = 1'b0;

	polar_seam_split_line_mapper_unit uut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint vector_length(longint e, longint n);
		longint s, r, b;
		s = e * e + n * n;
		r = 0;
		b = 64'sd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (e * e + n * n > r * r + r)
			r++;
		return (r > 65535) ? 65535 : r;
	endfunction

	function automatic longint cordic_bearing(longint e, longint n);
		longint x, y, z, t, xs, ys;
		x = n * 1048576;
		y = e * 1048576;
		z = 0;
		if (e == 0 && n == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 64'sd1 << 30;
			end else begin
				x = -y;
				y = t;
				z = -(64'sd1 << 30);
			end
		end
		for (int i = 0; i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TURNS[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TURNS[i];
			end
		end
		return (z + (64'sd1 << 15)) >>> 16;
	endfunction

	function automatic longint seam_length(longint rng, longint step, longint edge_az);
		longint v;
		if (step == 0)
			return prev_rng;
		v = ((rng - prev_rng) * (edge_az - prev_az) + prev_rng * step) / step;
		return (v < -65536) ? -65536 : ((v > 65535) ? 65535 : v);
	endfunction

	function automatic void push_point(longint az, longint rng, logic last);
		point_t p;
		p.az = AZW'(az);
		p.rng = RW'(rng);
		p.last = last;
		point_q.push_back(p);
	endfunction

	function automatic void map_vertex(item_t v);
		longint rng, a, d, first_az, second_az, ty;
		logic signed [AZW-1:0] a_wrap;
		rng = vector_length(longint'(v.east), longint'(v.north));
		a = cordic_bearing(longint'(v.east), longint'(v.north));
		if (v.start)
			has_prev = 1'b0;
		if (a < win_low)
			a = a + ((win_low - a + FULL_CIRCLE - 1) >> 16) * FULL_CIRCLE;
		if (a >= win_high)
			a = a - (((a - win_high) >> 16) + 1) * FULL_CIRCLE;
		a_wrap = AZW'(a);
		a = longint'(a_wrap);
		if (has_prev) begin
			d = a - prev_az;
			if (d > HALF_CIRCLE || d < -HALF_CIRCLE) begin
				if (a > prev_az) begin
					first_az = win_low;
					second_az = win_high;
					ty = seam_length(rng, d - FULL_CIRCLE, first_az);
				end else begin
					first_az = win_high;
					second_az = win_low;
					ty = seam_length(rng, d + FULL_CIRCLE, first_az);
				end
				push_point(first_az, ty, 1'b0);
				push_point(first_az, -1, 1'b0);
				push_point(second_az, -1, 1'b0);
				push_point(second_az, ty, 1'b0);
			end
		end
		push_point(a, rng, 1'b1);
		prev_az = a;
		prev_rng = rng;
		has_prev = 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d (point %0d)", what, got, want, points_seen);
		errors++;
	endtask

	// driver: hold the item until taken, then advance
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			map_vertex(drv_item);
		if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && vertex_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_item = vertex_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {drv_item.north, drv_item.east};
				s_axis_tuser <= drv_item.start;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		point_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (point_q.size() == 0) begin
				$display("unexpected result item: tdata %h", m_axis_tdata);
				errors++;
			end else begin
				want = point_q.pop_front();
				if ($signed(m_axis_tdata[17:0]) !== want.az)
					report_mismatch("azimuth", $signed(m_axis_tdata[17:0]), want.az);
				if ($signed(m_axis_tdata[34:18]) !== want.rng)
					report_mismatch("range", $signed(m_axis_tdata[34:18]), want.rng);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", m_axis_tlast, want.last);
			end
			points_seen++;
		end
		// hold off once so the input queue fills and backs up
		if (!hold_done && points_seen == 60) begin
			hold_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left != 0)
			hold_left--;
		m_axis_tready <= arst_n && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("polar_seam_split_line_mapper_unit regression: fail");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= AZW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == 1'(CFG_LOW))
			win_low = val;
		else
			win_high = val;
	endtask

	task automatic add_vertex(input longint e, input longint n, input logic start);
		item_t v;
		v.east = CW'(e);
		v.north = CW'(n);
		v.start = start;
		vertex_q.push_back(v);
	endtask

	task automatic drain;
		while (vertex_q.size() != 0 || s_axis_tvalid || point_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly lines with random content; some hug the south axis to cross the seam often
	task automatic add_random_line(input int n_items);
		longint e, n;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(3) == 0) begin
				e = $signed($urandom_range(255)) - 128;
				n = -$signed($urandom_range(32768));
			end else begin
				e = $signed($urandom_range(65535)) - 32768;
				n = $signed($urandom_range(65535)) - 32768;
			end
			add_vertex(e, n, i == 0 || $urandom_range(9) == 0);
		end
	endtask

	initial begin
		longint lows[7]  = '{-65536, 0, -65536, -12345, 65536, -100, -32768};
		longint highs[7] = '{65536, 65536, 0, 53191, -65536, 20000, 32768};
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero vector, seam rise and fall, restarted line
		add_vertex(0, 0, 1);
		add_vertex(32767, 0, 0);
		add_vertex(-32768, 0, 0);
		add_vertex(0, 32767, 0);
		add_vertex(0, -32768, 0);
		add_vertex(-32768, -32768, 0);
		add_vertex(32767, 32767, 0);
		add_vertex(1, -32768, 0);
		add_vertex(-1, -32768, 0);
		add_vertex(1, -32768, 0);
		add_vertex(-1, -32768, 1);
		add_vertex(32767, -32768, 0);
		add_vertex(-32768, 32767, 0);
		add_vertex(-300, -20000, 0);
		add_vertex(300, -100, 0);
		add_vertex(0, 0, 0);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 74;
				recv_idle_pct = 38;
			end else if (ph == 5) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(1'(CFG_LOW), lows[ph]);
			write_reg(1'(CFG_HIGH), highs[ph]);
			if (ph == 0) begin
				// wide window: exact south from both sides gives a full-circle step
				add_vertex(-1, -32768, 1);
				add_vertex(0, -32768, 0);
				add_vertex(0, -32768, 1);
				add_vertex(-1, -32768, 0);
			end
			add_random_line(21);
			drain();
		end

		if (errors == 0 && point_q.size() == 0)
			$display("polar_seam_split_line_mapper_unit regression: pass");
		else
			$display("polar_seam_split_line_mapper_unit regression: fail");
		$finish;
	end
endmodule
